[sv/ssl_pkg.sv]
// ----------------------------------------------------------------------------
// ssl_pkg: shared constants and types of the soft saturation limiter
// Sample format, Q4.20 working format, divider geometry, register codes and
// the sideband that travels with a sample through the lane pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package ssl_pkg;

    localparam int SAMPLE_WIDTH = 24;
    // Normalization shift between sample and Q4.20 domains.
    localparam int NORM_SHIFT = 41 - SAMPLE_WIDTH;

    localparam int QF = 20;             // fraction bits of Q4.20
    localparam int QW = 23;             // Q4.20 magnitude width
    localparam int HQ_W = 20;           // knee h stays below 1.0
    localparam int T_W = 22;            // scale t stays at or below 2.0
    localparam int YW = 21;             // shaped magnitude stays at or below 1.0

    localparam logic [QW-1:0] QONE = QW'(1) << QF;
    localparam logic [QW-1:0] QMAX = '1;

    // Pipelined divider: quotient bits, divisor width, numerator width.
    localparam int DIV_QB = 23;
    localparam int DIV_DW = 22;
    localparam int DIV_NW = DIV_QB + DIV_DW;

    // Configuration port
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int THR_W = 16;
    localparam int HARD_W = 12;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD = 2'd0,
        REG_HARDNESS  = 2'd1
    } reg_idx_t;

    localparam logic [THR_W-1:0] THR_MIN = 16'd16;
    localparam logic [THR_W-1:0] THR_MAX = 16'd32768;
    localparam logic [THR_W-1:0] THR_RST = 16'd32768;
    localparam logic [HARD_W-1:0] HARD_MAX = 12'd2048;
    localparam logic [HARD_W-1:0] HARD_RST = 12'd1024;
    localparam int HARD_DIV = 2049;

    // ceil(2^44 / HARD_DIV): (hard * HARD_RECIP) >> HARD_RECIP_SHIFT equals
    // floor(hard * 2^20 / HARD_DIV) exactly for every hardness up to 2048.
    localparam int HARD_RECIP_W = 33;
    localparam logic [HARD_RECIP_W-1:0] HARD_RECIP = 33'd8585742336;
    localparam int HARD_RECIP_SHIFT = 24;

    typedef struct packed {
        logic                    tag;
        logic                    bypass;
        logic                    neg;
        logic                    sat;
        logic [QW-1:0]           a;
        logic [SAMPLE_WIDTH-1:0] raw;
    } side_t;

    typedef struct packed {
        logic [HQ_W-1:0] h;
        logic [T_W-1:0]  t;
    } coef_t;

endpackage

`default_nettype wire

[sv/ssl_ifs.sv]
// ----------------------------------------------------------------------------
// ssl_ifs: channel interfaces of the soft saturation limiter
// Frame input, result output and register write channels, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssl_frame_if;
    logic                              valid;
    logic                              ready;
    logic [ssl_pkg::SAMPLE_WIDTH-1:0]  left_in;
    logic [ssl_pkg::SAMPLE_WIDTH-1:0]  right_in;
    logic                              bypass;
    logic                              block_end;

    modport source (output valid, left_in, right_in, bypass, block_end, input ready);
    modport sink (input valid, left_in, right_in, bypass, block_end, output ready);
endinterface

interface ssl_result_if;
    logic                              valid;
    logic                              ready;
    logic [ssl_pkg::SAMPLE_WIDTH-1:0]  left_out;
    logic [ssl_pkg::SAMPLE_WIDTH-1:0]  right_out;
    logic                              block_end_out;

    modport source (output valid, left_out, right_out, block_end_out, input ready);
    modport sink (input valid, left_out, right_out, block_end_out, output ready);
endinterface

interface ssl_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [ssl_pkg::CFG_IDX_W-1:0]    index;
    logic [ssl_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[sv/ssl_div.sv]
// ----------------------------------------------------------------------------
// ssl_div: pipelined restoring divider
// One quotient bit per stage, one division entering per cycle with en high.
// The numerator must give a quotient below 2^DIV_QB. A sideband word rides along.
// ----------------------------------------------------------------------------
`default_nettype none

module ssl_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic [ssl_pkg::DIV_NW-1:0]    in_num,
    input  wire logic [ssl_pkg::DIV_DW-1:0]    in_den,
    input  ssl_pkg::side_t                     in_side,
    output logic                               out_valid,
    output logic [ssl_pkg::DIV_QB-1:0]         out_quo,
    output ssl_pkg::side_t                     out_side
);

    localparam int QB = ssl_pkg::DIV_QB;
    localparam int DW = ssl_pkg::DIV_DW;
    localparam int NW = ssl_pkg::DIV_NW;

    logic                vld_reg  [QB];
    logic [DW-1:0]       rem_reg  [QB];
    logic [QB-1:0]       low_reg  [QB];
    logic [QB-1:0]       quo_reg  [QB];
    logic [DW-1:0]       den_reg  [QB];
    ssl_pkg::side_t      side_reg [QB];

    for (genvar k = 0; k < QB; k++)
    begin : g_stage
        logic           p_vld;
        logic [DW-1:0]  p_rem;
        logic [DW-1:0]  p_den;
        logic [QB-1:0]  p_low;
        logic [QB-1:0]  p_quo;
        ssl_pkg::side_t p_side;
        logic [DW:0]    trial;
        logic           ge;

        if (k == 0)
        begin : g_first
            assign p_vld  = in_valid;
            assign p_rem  = in_num[NW-1:QB];
            assign p_low  = in_num[QB-1:0];
            assign p_quo  = '0;
            assign p_den  = in_den;
            assign p_side = in_side;
        end
        else
        begin : g_next
            assign p_vld  = vld_reg[k-1];
            assign p_rem  = rem_reg[k-1];
            assign p_low  = low_reg[k-1];
            assign p_quo  = quo_reg[k-1];
            assign p_den  = den_reg[k-1];
            assign p_side = side_reg[k-1];
        end

        assign trial = {p_rem, p_low[QB-1]};
        assign ge    = (trial >= {1'b0, p_den});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= p_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= ge ? DW'(trial - {1'b0, p_den}) : trial[DW-1:0];
                low_reg[k]  <= {p_low[QB-2:0], 1'b0};
                quo_reg[k]  <= {p_quo[QB-2:0], ge};
                den_reg[k]  <= p_den;
                side_reg[k] <= p_side;
            end
        end
    end

    assign out_valid = vld_reg[QB-1];
    assign out_quo   = quo_reg[QB-1];
    assign out_side  = side_reg[QB-1];

endmodule

`default_nettype wire

[sv/ssl_coef.sv]
// ----------------------------------------------------------------------------
// ssl_coef: register file and coefficient unit
// Holds threshold and hardness, and after reset or any write derives the knee
// h with a reciprocal multiply and the scale t with a 42-step bit-serial divider.
// ----------------------------------------------------------------------------
`default_nettype none

module ssl_coef (
    input  wire logic        clk,
    input  wire logic        rst_n,
    ssl_cfg_if.sink          ctrl,
    output logic             busy,
    output ssl_pkg::coef_t   coef
);

    localparam int STEPS = 42;
    localparam int CW = 6;
    localparam int PRW = ssl_pkg::HARD_W + ssl_pkg::HARD_RECIP_W;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_LOAD_H = 3'b010,
        ST_DIV_T  = 3'b100
    } coef_st_t;

    coef_st_t                        state_reg;
    logic [CW-1:0]                   cnt_reg;
    logic [ssl_pkg::THR_W-1:0]       thr_reg;
    logic [ssl_pkg::HARD_W-1:0]      hard_reg;
    logic [STEPS-1:0]                num_reg;
    logic [ssl_pkg::DIV_DW-1:0]      rem_reg;
    logic [ssl_pkg::DIV_DW-1:0]      den_reg;
    logic [ssl_pkg::HQ_W-1:0]        h_reg;
    logic [ssl_pkg::T_W-1:0]         t_reg;

    logic                            wr;
    logic [ssl_pkg::THR_W-1:0]       thr_wr;
    logic [ssl_pkg::HARD_W-1:0]      hard_wr;
    logic [ssl_pkg::DIV_DW:0]        trial;
    logic                            ge;
    logic [ssl_pkg::DIV_DW-1:0]      rem_next;
    logic [STEPS-1:0]                num_next;
    logic                            last;
    logic [PRW-1:0]                  h_prod;
    logic [ssl_pkg::HQ_W-1:0]        h_calc;

    assign ctrl.ready = 1'b1;
    assign wr = ctrl.valid && ctrl.ready;

    always_comb
    begin
        thr_wr = ctrl.data[ssl_pkg::THR_W-1:0];
        if (thr_wr < ssl_pkg::THR_MIN)
            thr_wr = ssl_pkg::THR_MIN;
        if (thr_wr > ssl_pkg::THR_MAX)
            thr_wr = ssl_pkg::THR_MAX;
        hard_wr = ctrl.data[ssl_pkg::HARD_W-1:0];
        if (hard_wr > ssl_pkg::HARD_MAX)
            hard_wr = ssl_pkg::HARD_MAX;
    end

    // Knee h = hard * 2^20 / 2049 by reciprocal multiplication.
    assign h_prod = PRW'(hard_reg) * PRW'(ssl_pkg::HARD_RECIP);
    assign h_calc = h_prod[ssl_pkg::HARD_RECIP_SHIFT +: ssl_pkg::HQ_W];

    assign trial    = {rem_reg, num_reg[STEPS-1]};
    assign ge       = (trial >= {1'b0, den_reg});
    assign rem_next = ge ? ssl_pkg::DIV_DW'(trial - {1'b0, den_reg})
                         : trial[ssl_pkg::DIV_DW-1:0];
    assign num_next = {num_reg[STEPS-2:0], ge};
    assign last     = (cnt_reg == CW'(STEPS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD_H;
            cnt_reg   <= '0;
            thr_reg   <= ssl_pkg::THR_RST;
            hard_reg  <= ssl_pkg::HARD_RST;
        end
        else
        begin
            cnt_reg <= (state_reg == ST_DIV_T && !last) ? cnt_reg + CW'(1) : '0;
            // A write restarts the derivation from the new register values.
            if (wr)
            begin
                state_reg <= ST_LOAD_H;
            end
            else
            begin
                unique case (state_reg)
                    ST_IDLE:   state_reg <= ST_IDLE;
                    ST_LOAD_H: state_reg <= ST_DIV_T;
                    ST_DIV_T:  state_reg <= last ? ST_IDLE : ST_DIV_T;
                    default:   state_reg <= ST_LOAD_H;
                endcase
            end
            if (wr && ctrl.index == ssl_pkg::REG_THRESHOLD && ctrl.data != '0)
                thr_reg <= thr_wr;
            if (wr && ctrl.index == ssl_pkg::REG_HARDNESS && hard_wr != '0)
                hard_reg <= hard_wr;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_LOAD_H:
            begin
                h_reg   <= h_calc;
                num_reg <= STEPS'(thr_reg) << 26;
                rem_reg <= '0;
                den_reg <= ssl_pkg::DIV_DW'(h_calc) + ssl_pkg::DIV_DW'(ssl_pkg::QONE);
            end
            ST_DIV_T:
            begin
                num_reg <= num_next;
                rem_reg <= rem_next;
                if (last)
                    t_reg <= (num_next == '0) ? ssl_pkg::T_W'(1)
                                              : num_next[ssl_pkg::T_W-1:0];
            end
            default:
            begin
                num_reg <= num_reg;
            end
        endcase
    end

    assign busy   = (state_reg != ST_IDLE);
    assign coef.h = h_reg;
    assign coef.t = t_reg;

endmodule

`default_nettype wire

[sv/ssl_lane.sv]
// ----------------------------------------------------------------------------
// ssl_lane: one channel of the soft saturation curve
// Normalize by division, shape the knee region with two divisions and a square,
// rescale by t and saturate. Fully pipelined, one sample per cycle with en high.
// ----------------------------------------------------------------------------
`default_nettype none

module ssl_lane (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              en,
    input  wire logic                              in_valid,
    input  wire logic [ssl_pkg::SAMPLE_WIDTH-1:0]  sample,
    input  wire logic                              bypass,
    input  wire logic                              tag,
    input  ssl_pkg::coef_t                         coef,
    output logic                                   out_valid,
    output logic [ssl_pkg::SAMPLE_WIDTH-1:0]       out_sample,
    output logic                                   out_tag
);

    localparam int SW = ssl_pkg::SAMPLE_WIDTH;
    localparam int QW = ssl_pkg::QW;
    localparam int NW = ssl_pkg::DIV_NW;
    localparam int DW = ssl_pkg::DIV_DW;
    localparam int SQW = 2 * (ssl_pkg::QF + 1);
    localparam int PW = ssl_pkg::YW + ssl_pkg::T_W;
    localparam logic [PW-1:0] SIGN_BIT = PW'(1) << (SW - 1);

    // Knee excess; zero outside the knee region keeps the quotients bounded.
    function automatic logic [QW-1:0] knee_excess(input logic [QW-1:0] a,
                                                  input logic [QW-1:0] h);
        logic [QW-1:0] d;
        d = '0;
        if (a > h && a <= ssl_pkg::QONE)
            d = a - h;
        return d;
    endfunction

    logic [QW-1:0]        h_ext;
    logic                 neg0;
    logic [SW-1:0]        mag0;
    logic [NW-1:0]        num0;
    logic                 sat0;
    ssl_pkg::side_t       side0;

    logic                 v1;
    logic [DW:0]          q1_pad;
    logic [ssl_pkg::DIV_QB-1:0] q1;
    ssl_pkg::side_t       s1;
    ssl_pkg::side_t       s1_fix;
    logic                 v1_reg;
    ssl_pkg::side_t       s1_reg;

    logic [QW-1:0]        d2;
    logic                 v2;
    logic [ssl_pkg::DIV_QB-1:0] q2;
    ssl_pkg::side_t       s2;

    logic                 vm1_reg;
    logic [SQW-1:0]       sq_reg;
    ssl_pkg::side_t       sm1_reg;
    logic                 vm2_reg;
    logic [DW-1:0]        den3_reg;
    ssl_pkg::side_t       sm2_reg;

    logic [QW-1:0]        d3;
    logic                 v3;
    logic [ssl_pkg::DIV_QB-1:0] q3;
    ssl_pkg::side_t       s3;

    logic [QW-1:0]        y_comb;
    logic                 vy_reg;
    logic [ssl_pkg::YW-1:0] y_reg;
    ssl_pkg::side_t       sy_reg;

    logic                 vp_reg;
    logic [PW-1:0]        prod_reg;
    ssl_pkg::side_t       sp_reg;

    logic [PW-1:0]        o_mag;
    logic [SW-1:0]        o_res;
    logic                 vo_reg;
    logic [SW-1:0]        o_reg;
    logic                 to_reg;

    assign h_ext = QW'(coef.h);

    // Normalize: a = |s| * 2^NORM_SHIFT / t, saturated where it reaches 2^23.
    assign neg0  = sample[SW-1];
    assign mag0  = neg0 ? SW'(-sample) : sample;
    assign num0  = NW'(mag0) << ssl_pkg::NORM_SHIFT;
    assign sat0  = (num0 >= (NW'(coef.t) << ssl_pkg::DIV_QB));

    always_comb
    begin
        side0        = '0;
        side0.tag    = tag;
        side0.bypass = bypass;
        side0.neg    = neg0;
        side0.sat    = sat0;
        side0.raw    = sample;
    end

    ssl_div u_div_norm (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_valid),
        .in_num   (sat0 ? '0 : num0),
        .in_den   (DW'(coef.t)),
        .in_side  (side0),
        .out_valid(v1),
        .out_quo  (q1),
        .out_side (s1)
    );

    assign q1_pad = (DW + 1)'(q1);

    always_comb
    begin
        s1_fix   = s1;
        s1_fix.a = s1.sat ? ssl_pkg::QMAX : q1_pad[QW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            vm1_reg <= 1'b0;
            vm2_reg <= 1'b0;
            vy_reg  <= 1'b0;
            vp_reg  <= 1'b0;
            vo_reg  <= 1'b0;
        end
        else if (en)
        begin
            v1_reg  <= v1;
            vm1_reg <= v2;
            vm2_reg <= vm1_reg;
            vy_reg  <= v3;
            vp_reg  <= vy_reg;
            vo_reg  <= vp_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= s1_fix;
        end
    end

    // Knee ratio q = d / (1 - h)
    assign d2 = knee_excess(s1_reg.a, h_ext);

    ssl_div u_div_ratio (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (v1_reg),
        .in_num   (NW'(d2) << ssl_pkg::QF),
        .in_den   (DW'(ssl_pkg::QONE - h_ext)),
        .in_side  (s1_reg),
        .out_valid(v2),
        .out_quo  (q2),
        .out_side (s2)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg   <= SQW'(q2[ssl_pkg::QF:0]) * SQW'(q2[ssl_pkg::QF:0]);
            sm1_reg  <= s2;
            den3_reg <= DW'(ssl_pkg::QONE) + DW'(sq_reg[SQW-1:ssl_pkg::QF]);
            sm2_reg  <= sm1_reg;
        end
    end

    // Knee curve term d / (1 + q^2)
    assign d3 = knee_excess(sm2_reg.a, h_ext);

    ssl_div u_div_knee (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (vm2_reg),
        .in_num   (NW'(d3) << ssl_pkg::QF),
        .in_den   (den3_reg),
        .in_side  (sm2_reg),
        .out_valid(v3),
        .out_quo  (q3),
        .out_side (s3)
    );

    always_comb
    begin
        priority if (s3.a > ssl_pkg::QONE)
            y_comb = (h_ext + ssl_pkg::QONE) >> 1;
        else if (s3.a > h_ext)
            y_comb = h_ext + q3[QW-1:0];
        else
            y_comb = s3.a;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y_reg    <= y_comb[ssl_pkg::YW-1:0];
            sy_reg   <= s3;
            prod_reg <= PW'(y_reg) * PW'(coef.t);
            sp_reg   <= sy_reg;
        end
    end

    // Rescale, apply sign, saturate to the sample width.
    assign o_mag = prod_reg >> ssl_pkg::NORM_SHIFT;

    always_comb
    begin
        if (sp_reg.bypass)
            o_res = sp_reg.raw;
        else if (sp_reg.neg)
            o_res = (o_mag > SIGN_BIT) ? SW'(-SIGN_BIT[SW-1:0])
                                       : SW'(-o_mag[SW-1:0]);
        else
            o_res = (o_mag > SIGN_BIT - PW'(1)) ? SW'(SIGN_BIT - PW'(1))
                                                : o_mag[SW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_reg  <= o_res;
            to_reg <= sp_reg.tag;
        end
    end

    assign out_valid  = vo_reg;
    assign out_sample = o_reg;
    assign out_tag    = to_reg;

endmodule

`default_nettype wire

[sv/soft_saturation_limiter_top.sv]
// ----------------------------------------------------------------------------
// soft_saturation_limiter_top: stereo soft saturation limiter
// Two lanes shape the left and right samples side by side; an output
// register merges their results with the block end mark.
//
//   channel   dir   handshake      payload
//   frames    in    valid/ready    left_in, right_in, bypass, block_end
//   results   out   valid/ready    left_out, right_out, block_end_out
//   ctrl      in    valid/ready    index, data (register write)
//
// One frame per cycle while the result channel does not stall and no
// coefficient derivation runs; each lane holds three 23-stage pipelined dividers.
// After reset and after each register write the coefficient unit derives
// h and t with its bit-serial divider; frames wait meanwhile.
// A stalled result holds the pipeline only when the last lane stage is full.
// ----------------------------------------------------------------------------
`default_nettype none

module soft_saturation_limiter_top (
    input  wire logic      clk,
    input  wire logic      rst_n,
    ssl_frame_if.sink      frames,
    ssl_result_if.source   results,
    ssl_cfg_if.sink        ctrl
);

    localparam int SW = ssl_pkg::SAMPLE_WIDTH;

    logic              busy;
    ssl_pkg::coef_t    coef;
    logic              en;
    logic              accept;
    logic              lv_l;
    logic              lv_r;
    logic [SW-1:0]     ls_l;
    logic [SW-1:0]     ls_r;
    logic              lt_l;
    logic              lt_r;

    logic              out_vld_reg;
    logic [SW-1:0]     left_reg;
    logic [SW-1:0]     right_reg;
    logic              end_reg;

    ssl_coef u_coef (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .busy  (busy),
        .coef  (coef)
    );

    // Advance unless a finished result would overwrite one still waiting.
    assign en            = !lv_l || !out_vld_reg || results.ready;
    assign frames.ready  = en && !busy;
    assign accept        = frames.valid && frames.ready;

    ssl_lane u_lane_left (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (accept),
        .sample    (frames.left_in),
        .bypass    (frames.bypass),
        .tag       (frames.block_end),
        .coef      (coef),
        .out_valid (lv_l),
        .out_sample(ls_l),
        .out_tag   (lt_l)
    );

    ssl_lane u_lane_right (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (accept),
        .sample    (frames.right_in),
        .bypass    (frames.bypass),
        .tag       (frames.block_end),
        .coef      (coef),
        .out_valid (lv_r),
        .out_sample(ls_r),
        .out_tag   (lt_r)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (!out_vld_reg || results.ready)
        begin
            out_vld_reg <= lv_l && en;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((!out_vld_reg || results.ready) && lv_l)
        begin
            left_reg  <= ls_l;
            right_reg <= ls_r;
            end_reg   <= lt_l;
        end
    end

    assign results.valid         = out_vld_reg;
    assign results.left_out      = left_reg;
    assign results.right_out     = right_reg;
    assign results.block_end_out = end_reg;

    a_lanes_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        (lv_l == lv_r) && (!lv_l || (lt_l == lt_r)))
        else $error("lanes out of step");

    a_write_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.valid && ctrl.ready) |=> busy)
        else $error("coefficient unit not restarted by write");

    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (lv_l && out_vld_reg && !results.ready) |-> !frames.ready)
        else $error("request taken while result path is stalled");

    a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !results.ready) |=> out_vld_reg)
        else $error("waiting result dropped");

endmodule

`default_nettype wire

[verif/ssl_checker.sv]
// ----------------------------------------------------------------------------
// ssl_checker: result predictor and scoreboard of the soft saturation limiter
// Watches the frame, result and register write channels, computes the shaped
// samples of each accepted frame and compares them in order with the results.
// ----------------------------------------------------------------------------
`default_nettype none

module ssl_checker (
    input  wire logic clk,
    input  wire logic rst_n,
    ssl_frame_if.sink   frames,
    ssl_result_if.sink  results,
    ssl_cfg_if.sink     ctrl,
    output int          fail_count,
    output int          pending,
    output int          result_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SW = ssl_pkg::SAMPLE_WIDTH;

    typedef struct packed {
        logic [SW-1:0] left;
        logic [SW-1:0] right;
        logic          last;
    } shaped_frame_t;

    shaped_frame_t shaped_q[$];
    logic [15:0] thr_level;
    logic [11:0] hard_level;

    function automatic logic [SW-1:0] shape(logic [SW-1:0] raw,
                                            longint unsigned hq,
                                            longint unsigned tq);
        longint unsigned one;
        longint unsigned mag;
        longint unsigned a;
        longint unsigned y;
        longint unsigned d;
        longint unsigned q;
        longint unsigned den;
        longint unsigned o;
        longint unsigned top;
        logic neg;
        one = 64'd1 << 20;
        neg = raw[SW-1];
        mag = neg ? longint'(SW'(-raw)) : longint'(raw);
        if (neg && mag == 0)
            mag = 64'd1 << (SW - 1);
        a = (mag << ssl_pkg::NORM_SHIFT) / tq;
        if (a > (64'd1 << 23) - 1)
            a = (64'd1 << 23) - 1;
        if (a > one)
            y = (hq + one) >> 1;
        else if (a > hq)
        begin
            d = a - hq;
            q = (d << 20) / (one - hq);
            den = one + ((q * q) >> 20);
            y = hq + (d << 20) / den;
        end
        else
            y = a;
        o = (y * tq) >> ssl_pkg::NORM_SHIFT;
        top = 64'd1 << (SW - 1);
        if (neg)
        begin
            if (o > top)
                o = top;
            return SW'(-o);
        end
        if (o > top - 1)
            o = top - 1;
        return SW'(o);
    endfunction

    function automatic shaped_frame_t predict_frame(logic [SW-1:0] l,
                                                    logic [SW-1:0] r,
                                                    logic byp, logic last);
        shaped_frame_t f;
        longint unsigned hq;
        longint unsigned tq;
        hq = (longint'(hard_level) << 20) / ssl_pkg::HARD_DIV;
        tq = (longint'(thr_level) << 26) / (hq + (64'd1 << 20));
        if (tq == 0)
            tq = 1;
        f.left = byp ? l : shape(l, hq, tq);
        f.right = byp ? r : shape(r, hq, tq);
        f.last = last;
        return f;
    endfunction

    assign pending = shaped_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_level <= ssl_pkg::THR_RST;
            hard_level <= ssl_pkg::HARD_RST;
            fail_count <= 0;
            result_count <= 0;
            shaped_q.delete();
        end
        else
        begin
            if (ctrl.valid && ctrl.ready)
            begin
                if (ctrl.index == ssl_pkg::REG_THRESHOLD && ctrl.data != 0)
                    thr_level <= (ctrl.data < ssl_pkg::THR_MIN) ? ssl_pkg::THR_MIN :
                                 (ctrl.data > ssl_pkg::THR_MAX) ? ssl_pkg::THR_MAX
                                                                : ctrl.data;
                else if (ctrl.index == ssl_pkg::REG_HARDNESS && ctrl.data[11:0] != 0)
                    hard_level <= (ctrl.data[11:0] > ssl_pkg::HARD_MAX) ? ssl_pkg::HARD_MAX
                                                                        : ctrl.data[11:0];
            end
            if (frames.valid && frames.ready)
                shaped_q.push_back(predict_frame(frames.left_in, frames.right_in,
                                                 frames.bypass, frames.block_end));
            if (results.valid && results.ready)
            begin
                shaped_frame_t exp_f;
                result_count <= result_count + 1;
                if (shaped_q.size() == 0)
                begin
                    $error("result with no frame waiting");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_f = shaped_q.pop_front();
                    if (results.left_out !== exp_f.left)
                        $error("left_out: expected %0d, got %0d",
                               $signed(exp_f.left), $signed(results.left_out));
                    if (results.right_out !== exp_f.right)
                        $error("right_out: expected %0d, got %0d",
                               $signed(exp_f.right), $signed(results.right_out));
                    if (results.block_end_out !== exp_f.last)
                        $error("block_end_out: expected %0d, got %0d",
                               exp_f.last, results.block_end_out);
                    if (results.left_out !== exp_f.left || results.right_out !== exp_f.right
                        || results.block_end_out !== exp_f.last)
                        fail_count <= fail_count + 1;
                end
            end
        end
    end
endmodule

`default_nettype wire

[verif/soft_saturation_limiter_top_test.sv]
// ----------------------------------------------------------------------------
// soft_saturation_limiter_top_test: stimulus for the soft saturation limiter
// Drives directed and random stereo frames under several register settings
// and idle patterns; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none

module soft_saturation_limiter_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SW = ssl_pkg::SAMPLE_WIDTH;
    localparam int LATENCY = 76;
    localparam int COEF_CYCLES = 43;
    localparam int WATCHDOG = 4000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   fail_count;
    int   pending;
    int   result_count;
    int   idle_cycles = 0;
    int   send_idle = 0;
    int   recv_stall = 0;
    int   frames_sent = 0;
    int   settings_used = 0;

    ssl_frame_if  frames();
    ssl_result_if results();
    ssl_cfg_if    ctrl();

    soft_saturation_limiter_top DUT (
        .clk(clk), .rst_n(rst_n), .frames(frames), .results(results), .ctrl(ctrl)
    );

    ssl_checker scoreboard (
        .clk(clk), .rst_n(rst_n), .frames(frames), .results(results), .ctrl(ctrl),
        .fail_count(fail_count), .pending(pending), .result_count(result_count)
    );

    always #1 clk = ~clk;

    initial
    begin
        frames.valid = 1'b0;
        frames.left_in = '0;
        frames.right_in = '0;
        frames.bypass = 1'b0;
        frames.block_end = 1'b0;
        results.ready = 1'b0;
        ctrl.valid = 1'b0;
        ctrl.index = '0;
        ctrl.data = '0;
    end

    // Stall the result channel at the rate of the current phase.
    always @(posedge clk)
        results.ready <= ($urandom_range(99) >= recv_stall);

    // Watchdog: count cycles with no accepted request on any channel.
    always @(posedge clk)
    begin
        if ((frames.valid && frames.ready) || (results.valid && results.ready)
            || (ctrl.valid && ctrl.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG)
        begin
            $display("watchdog expired with %0d results outstanding", pending);
            $display("soft_saturation_limiter_top_test: FAIL");
            $finish;
        end
    end

    function automatic logic [SW-1:0] pick_sample();
        case ($urandom_range(9))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'h000000;
            3: return 24'($signed(24'h000000) + $urandom_range(2048)) - 24'd1024;
            4, 5: return 24'($urandom_range(24'h3FFFFF)) ^ {24{$urandom_range(1) == 1}};
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic send_frame(logic [SW-1:0] l, logic [SW-1:0] r,
                              logic byp, logic last);
        while ($urandom_range(99) < send_idle)
        begin
            frames.valid <= 1'b0;
            @(posedge clk);
        end
        frames.valid <= 1'b1;
        frames.left_in <= l;
        frames.right_in <= r;
        frames.bypass <= byp;
        frames.block_end <= last;
        @(posedge clk);
        while (!frames.ready)
            @(posedge clk);
        frames_sent++;
    endtask

    task automatic drain();
        frames.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_reg(ssl_pkg::reg_idx_t idx, logic [15:0] value);
        ctrl.valid <= 1'b1;
        ctrl.index <= idx;
        ctrl.data <= value;
        @(posedge clk);
        while (!ctrl.ready)
            @(posedge clk);
        ctrl.valid <= 1'b0;
        settings_used++;
        repeat (COEF_CYCLES + 4) @(posedge clk);
    endtask

    task automatic random_frames(int count);
        for (int i = 0; i < count; i++)
            send_frame(pick_sample(), pick_sample(), $urandom_range(7) == 0,
                       $urandom_range(3) == 0);
    endtask

    initial
    begin
        logic [15:0] thr_set[8] = '{16'd32768, 16'd16, 16'd1000, 16'd20000,
                                    16'd5, 16'hFFFF, 16'd0, 16'd12345};
        logic [15:0] hard_set[8] = '{16'd2048, 16'd1, 16'd300, 16'd1500,
                                     16'h0FFF, 16'd0, 16'h1800, 16'd777};
        int phase_idle[4] = '{0, 87, 0, 10};
        int phase_stall[4] = '{0, 0, 87, 10};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (COEF_CYCLES + 4) @(posedge clk);

        // Directed: extremes, bypass, block end, around the knee at reset setting.
        send_frame(24'h7FFFFF, 24'h800000, 1'b0, 1'b0);
        send_frame(24'h000000, 24'hFFFFFF, 1'b0, 1'b1);
        send_frame(24'h7FFFFF, 24'h800000, 1'b1, 1'b0);
        send_frame(24'h000001, 24'h800001, 1'b1, 1'b1);
        send_frame(24'h400000, 24'hC00000, 1'b0, 1'b0);
        send_frame(24'h300000, 24'hD00000, 1'b0, 1'b0);
        send_frame(24'h555555, 24'hAAAAAA, 1'b0, 1'b1);
        drain();
        write_reg(ssl_pkg::REG_THRESHOLD, 16'd16);
        write_reg(ssl_pkg::REG_HARDNESS, 16'd2048);
        send_frame(24'h7FFFFF, 24'h800000, 1'b0, 1'b0);
        send_frame(24'h000010, 24'hFFFFF0, 1'b0, 1'b1);
        drain();
        write_reg(ssl_pkg::REG_THRESHOLD, 16'd32768);
        write_reg(ssl_pkg::REG_HARDNESS, 16'd1);
        send_frame(24'h7FFFFF, 24'h800000, 1'b0, 1'b0);
        send_frame(24'h100000, 24'hF00000, 1'b0, 1'b1);
        drain();
        // Unknown register indexes are ignored.
        ctrl.valid <= 1'b1;
        ctrl.index <= 2'd2;
        ctrl.data <= 16'd100;
        @(posedge clk);
        while (!ctrl.ready)
            @(posedge clk);
        ctrl.index <= 2'd3;
        ctrl.data <= 16'hFFFF;
        @(posedge clk);
        while (!ctrl.ready)
            @(posedge clk);
        ctrl.valid <= 1'b0;
        repeat (COEF_CYCLES + 4) @(posedge clk);
        send_frame(24'h600000, 24'hA00000, 1'b0, 1'b0);
        drain();

        for (int s = 0; s < 8; s++)
        begin
            write_reg(ssl_pkg::REG_THRESHOLD, thr_set[s]);
            write_reg(ssl_pkg::REG_HARDNESS, hard_set[s]);
            for (int p = 0; p < 4; p++)
            begin
                send_idle = phase_idle[p];
                recv_stall = phase_stall[p];
                random_frames(55);
            end
            send_idle = 0;
            recv_stall = 0;
            drain();
        end
        // A few fully random settings.
        for (int s = 0; s < 4; s++)
        begin
            write_reg(ssl_pkg::REG_THRESHOLD, 16'($urandom));
            write_reg(ssl_pkg::REG_HARDNESS, 16'($urandom));
            send_idle = phase_idle[s];
            recv_stall = phase_stall[s];
            random_frames(20);
            send_idle = 0;
            recv_stall = 0;
            drain();
        end

        $display("covered %0d frames, %0d results, %0d register writes",
                 frames_sent, result_count, settings_used);
        $display("idle phases: none, sender gaps, receiver stalls, both");
        if (fail_count == 0)
            $display("soft_saturation_limiter_top_test: PASS");
        else
            $display("soft_saturation_limiter_top_test: FAIL");
        $finish;
    end
endmodule

`default_nettype wire
